### sv/transposed_conv_2x2_stride2_macros.svh
// Assertion macros for the transposed convolution block.
`ifndef TRANSPOSED_CONV_2X2_STRIDE2_MACROS_SVH
`define TRANSPOSED_CONV_2X2_STRIDE2_MACROS_SVH
`ifndef SYNTHESIS
`define TC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/tc2_pkg.sv
// ----------------------------------------------------------------------------
// tc2_pkg
// Shared constants and types of the 2x2 stride 2 transposed convolution.
// ----------------------------------------------------------------------------
package tc2_pkg;
  localparam int OUT_CH_MAX_DEF = 16;
  localparam int IN_CH_MAX_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS      = 8;
  localparam int ACC_W          = 40;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_BIAS   = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  localparam logic [1:0] REG_IN_CH  = 2'd0;
  localparam logic [1:0] REG_OUT_CH = 2'd1;
  localparam logic [1:0] REG_BIAS   = 2'd2;
endpackage

### sv/tc2_ram.sv
// ----------------------------------------------------------------------------
// tc2_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tc2_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/transposed_conv_2x2_stride2.sv
// ----------------------------------------------------------------------------
// transposed_conv_2x2_stride2
// 2x2 stride 2 transposed convolution over one input location at a time.
// ----------------------------------------------------------------------------
// channel   dir  content
// s_axis    in   tdata: in_ch, out_ch, tap, value ; tuser: kind
// m_axis    out  tdata: res_out_ch, sub_row, sub_col, res_value ; tlast: last
// cfg       in   cfg_we, cfg_index, cfg_data
//
// A load beat or a dropped beat leaves the input open for the next beat. A
// sample beat closes the input for its sweep: one accumulator read per tap
// per output channel, then the last write-back, then the sweep is left; the
// single accumulator read port paces the sweep.
// For the last channel of a location the input stays closed while each result
// is read, then loaded into the output register; an output stall holds it.
// Reset clears control only; stores are undefined until written.
// A stalled result holds in the output register and halts the drain; the input
// reopens once the last result of the location is loaded.
// ----------------------------------------------------------------------------
module transposed_conv_2x2_stride2 #(
  parameter int OUT_CH_MAX = tc2_pkg::OUT_CH_MAX_DEF,
  parameter int IN_CH_MAX  = tc2_pkg::IN_CH_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // in_ch[5:0], out_ch[9:6], tap[11:10], value[27:12], zero pad
  input  logic [31:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // res_out_ch[3:0], sub_row[4], sub_col[5], res_value[21:6], zero pad
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import tc2_pkg::*;

  localparam int OCW  = (OUT_CH_MAX > 1) ? $clog2(OUT_CH_MAX) : 1;
  localparam int ICW  = (IN_CH_MAX > 1) ? $clog2(IN_CH_MAX) : 1;
  localparam int ADW  = OCW + 2;
  localparam int WDEP = IN_CH_MAX * OUT_CH_MAX * 4;
  localparam int WAW  = $clog2(WDEP);
  localparam int NACC = OUT_CH_MAX * 4;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_OUT  = 3'd2;
  localparam logic [2:0] ST_HOLD = 3'd3;

  // unpack the input beat
  logic [5:0]  in_ch;
  logic [3:0]  out_ch;
  logic [1:0]  tap;
  logic signed [15:0] value;
  assign in_ch  = s_axis_tdata[5:0];
  assign out_ch = s_axis_tdata[9:6];
  assign tap    = s_axis_tdata[11:10];
  assign value  = s_axis_tdata[27:12];

  // configuration, clamped where used
  logic [6:0] in_channels;
  logic [4:0] out_channels;
  logic       bias_en;
  always_ff @(posedge clk) begin
    if (rst) begin
      in_channels  <= 7'd1;
      out_channels <= 5'd1;
      bias_en      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_CH:  in_channels  <= cfg_data;
        REG_OUT_CH: out_channels <= cfg_data[4:0];
        REG_BIAS:   bias_en      <= cfg_data[0];
        default: ;
      endcase
    end
  end
  logic [8:0] nic;
  logic [4:0] noc;
  always_comb begin
    nic = (in_channels == 7'd0) ? 9'd1 :
          ({2'd0, in_channels} > 9'(IN_CH_MAX)) ? 9'(IN_CH_MAX) : {2'd0, in_channels};
    noc = (out_channels == 5'd0) ? 5'd1 :
          (out_channels > 5'(OUT_CH_MAX)) ? 5'(OUT_CH_MAX) : out_channels;
  end

  logic [2:0] state;
  logic [ICW-1:0] cur_ic;
  logic signed [15:0] cur_val;
  logic seed, fin;
  logic [ADW:0] rd_idx;     // read sweep counter over accumulators
  logic         p_vld;      // read data valid next cycle stage
  logic [ADW-1:0] p_idx;
  logic [ADW:0] total;
  assign total = (ADW+1)'({noc, 2'b00});

  // memories
  logic           w_we;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [15:0]    w_rdata;
  logic           b_we;
  logic [15:0]    b_rdata;
  logic [OCW-1:0] b_raddr;
  logic           a_we;
  logic [ADW-1:0] a_waddr, a_raddr;
  logic [ACC_W-1:0] a_wdata, a_rdata;

  logic acc_in, sample_ok;
  assign s_axis_tready = (state == ST_IDLE);
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign sample_ok = (s_axis_tuser == KIND_SAMPLE) && ({3'd0, in_ch} < nic);

  assign w_we = acc_in && (s_axis_tuser == KIND_WEIGHT) && ({3'd0, in_ch} < 9'(IN_CH_MAX))
                && ({1'b0, out_ch} < 5'(OUT_CH_MAX));
  assign w_waddr = WAW'(({in_ch, 6'd0} >> 6) * (OUT_CH_MAX * 4) + out_ch * 4 + tap);
  assign w_raddr = WAW'(cur_ic * (OUT_CH_MAX * 4) + rd_idx[ADW-1:0]);
  assign b_we = acc_in && (s_axis_tuser == KIND_BIAS) && ({1'b0, out_ch} < 5'(OUT_CH_MAX));
  assign b_raddr = rd_idx[ADW-1:2];
  assign a_raddr = rd_idx[ADW-1:0];

  tc2_ram #(.WIDTH(16), .DEPTH(WDEP)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(value),
    .raddr(w_raddr), .rdata(w_rdata));
  tc2_ram #(.WIDTH(16), .DEPTH(OUT_CH_MAX)) u_bram (
    .clk(clk), .we(b_we), .waddr(OCW'(out_ch)), .wdata(value),
    .raddr(b_raddr), .rdata(b_rdata));
  tc2_ram #(.WIDTH(ACC_W), .DEPTH(NACC)) u_aram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata));

  // multiply-accumulate on the registered read data; each entry touched once
  // per sweep, so read and write-back never overlap on one entry
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] base;
  assign prod = cur_val * $signed(w_rdata);
  always_comb begin
    if (seed) begin
      base = bias_en ? (ACC_W'($signed(b_rdata)) <<< FRAC_BITS) : '0;
    end else begin
      base = a_rdata;
    end
  end
  assign a_we    = (state == ST_MAC) && p_vld;
  assign a_waddr = p_idx;
  assign a_wdata = base + ACC_W'(prod);

  // finish: floor shift and saturate
  logic signed [ACC_W-FRAC_BITS-1:0] shq;
  logic signed [15:0] sat;
  localparam logic signed [ACC_W-FRAC_BITS-1:0] HI = (1 <<< (DATA_WIDTH_DEF-1)) - 1;
  localparam logic signed [ACC_W-FRAC_BITS-1:0] LO = -(1 <<< (DATA_WIDTH_DEF-1));
  always_comb begin
    shq = $signed(a_rdata[ACC_W-1:FRAC_BITS]);
    if (shq > HI) sat = 16'(HI);
    else if (shq < LO) sat = 16'(LO);
    else sat = shq[15:0];
  end

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_idx <= '0;
      p_vld <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          p_vld <= 1'b0;
          if (acc_in && sample_ok) begin
            cur_ic <= ICW'(in_ch);
            cur_val <= value;
            seed <= (in_ch == 6'd0);
            fin <= ({3'd0, in_ch} + 9'd1 == nic);
            rd_idx <= '0;
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          // advance the read sweep; write back in the cycle after each read
          p_vld <= (rd_idx < total);
          p_idx <= rd_idx[ADW-1:0];
          if (rd_idx < total) rd_idx <= rd_idx + 1'b1;
          else if (!p_vld) begin
            rd_idx <= '0;
            state <= fin ? ST_OUT : ST_IDLE;
          end
        end
        ST_OUT: begin
          // read issue; data appears next cycle in HOLD
          if (out_free) begin
            p_idx <= rd_idx[ADW-1:0];
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {2'd0, sat, p_idx[0], p_idx[1], 4'(p_idx >> 2)};
          m_axis_tlast <= (rd_idx + 1'b1 == total);
          if (rd_idx + 1'b1 == total) begin
            rd_idx <= '0;
            state <= ST_IDLE;
          end else begin
            rd_idx <= rd_idx + 1'b1;
            state <= ST_OUT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `include "transposed_conv_2x2_stride2_macros.svh"
  `TC_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != ST_IDLE, !s_axis_tready)
  `TC_ASSERT_IMPL(a_wb_in_mac, clk, rst, a_we, state == ST_MAC)
  `TC_ASSERT_IMPL(a_out_only_free, clk, rst, state == ST_HOLD, out_free)
  `TC_ASSERT_NEXT(a_last_idle, clk, rst, state == ST_HOLD && rd_idx + 1'b1 == total,
                  state == ST_IDLE && m_axis_tlast)
endmodule

### tb/transposed_conv_2x2_stride2_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transposed_conv_2x2_stride2_tb
// Streams weight, bias and sample beats into the transposed convolution
// engine over several register settings, predicts every output pixel and
// checks each result beat in order, with random gaps on both sides.
// ----------------------------------------------------------------------------
module transposed_conv_2x2_stride2_tb;
  import tc2_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;  // unused kind, block drops it
  localparam int         SETTLE    = 120;   // worst sample work plus margin

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  ic;
    logic [3:0]  oc;
    logic [1:0]  tap;
    logic [15:0] val;
  } beat_t;

  typedef struct packed {
    logic [3:0]  oc;
    logic        row;
    logic        col;
    logic [15:0] val;
    logic        last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  transposed_conv_2x2_stride2 uut (.*);

  always #4 clk = ~clk;

  // Shadow of the engine: stores, accumulators and registers
  logic signed [15:0] wgt_mem [64][16][4];
  logic signed [15:0] bias_mem [16];
  logic        [39:0] acc_mem [16][4];
  bit                 w_set [64][16][4];  // weight entries loaded so far
  bit                 b_set [16];         // bias entries loaded so far
  int unsigned        n_in = 1, n_out = 1;
  logic               bias_on = 1'b0;
  bit                 seeded = 0;   // channel 0 seen since last setting change

  beat_t  beat_q [$];
  pixel_t pixel_q [$];
  int     errors = 0;
  int     in_gap = 0, out_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] to_q88(logic [39:0] acc);
    logic signed [39:0] sh;
    sh = $signed(acc) >>> FRAC_BITS;   // floor rounding
    if (sh > 40'sd32767) return 16'h7fff;
    if (sh < -40'sd32768) return 16'h8000;
    return sh[15:0];
  endfunction

  // Queue a beat and fold its effect into the shadow state
  task automatic send(input logic [1:0] kind, input logic [5:0] ic, input logic [3:0] oc,
                      input logic [1:0] tap, input logic [15:0] val);
    beat_t b;
    logic signed [31:0] prod;
    b = '{kind, ic, oc, tap, val};
    beat_q.push_back(b);
    if (kind == KIND_WEIGHT) begin
      wgt_mem[ic][oc][tap] = val;
      w_set[ic][oc][tap] = 1'b1;
    end else if (kind == KIND_BIAS) begin
      bias_mem[oc] = val;
      b_set[oc] = 1'b1;
    end else if (kind == KIND_SAMPLE && ic < n_in) begin
      if (ic == 0) seeded = 1;
      for (int m = 0; m < n_out; m++) begin
        for (int t = 0; t < 4; t++) begin
          if (ic == 0)
            acc_mem[m][t] = bias_on ? {{16{bias_mem[m][15]}}, bias_mem[m], 8'h00} : '0;
          prod = $signed(val) * wgt_mem[ic][m][t];
          acc_mem[m][t] = acc_mem[m][t] + {{8{prod[31]}}, prod};
        end
      end
      if (ic + 1 == n_in) begin
        for (int m = 0; m < n_out; m++) begin
          for (int t = 0; t < 4; t++) begin
            pixel_q.push_back('{m[3:0], t[1], t[0], to_q88(acc_mem[m][t]),
                                (m + 1 == n_out) && (t == 3)});
          end
        end
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (beat_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    // clamp as the block does
    if (idx == REG_IN_CH) n_in = (v == 0) ? 1 : ((v > 64) ? 64 : v);
    else if (idx == REG_OUT_CH) n_out = (v[4:0] == 0) ? 1 : ((v[4:0] > 16) ? 16 : v[4:0]);
    else if (idx == REG_BIAS) bias_on = v[0];
    seeded = 0;
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Load every weight and bias the current setting reads and that is still unset
  task automatic load_stores();
    for (int i = 0; i < n_in; i++) begin
      for (int o = 0; o < n_out; o++) begin
        for (int t = 0; t < 4; t++)
          if (!w_set[i][o][t]) send(KIND_WEIGHT, i[5:0], o[3:0], t[1:0], rand_val());
        if (bias_on && !b_set[o])
          send(KIND_BIAS, 6'($urandom()), o[3:0], 2'($urandom()), rand_val());
      end
    end
  endtask

  // One location: channels in order, with noise beats and repeats mixed in
  task automatic location();
    for (int c = 0; c < n_in; c++) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: send(KIND_NONE, 6'($urandom()), 4'($urandom()), 2'($urandom()),
                  16'($urandom()));
          1: send(KIND_WEIGHT, 6'($urandom()), 4'($urandom()), 2'($urandom()), rand_val());
          2: send(KIND_BIAS, 6'($urandom()), 4'($urandom()), 2'($urandom()), rand_val());
          default: if (n_in < 64)
            send(KIND_SAMPLE, 6'($urandom_range(n_in, 63)), 4'($urandom()),
                 2'($urandom()), 16'($urandom()));
        endcase
      end
      // occasionally repeat an earlier channel; channel 0 reseeds, any other adds again
      if (seeded && c > 0 && $urandom_range(0, 15) == 0)
        send(KIND_SAMPLE, 6'($urandom_range(0, c - 1)), 4'($urandom()), 2'($urandom()),
             rand_val());
      send(KIND_SAMPLE, c[5:0], 4'($urandom()), 2'($urandom()), rand_val());
    end
  endtask

  task automatic phase(input logic [6:0] ic_reg, input logic [6:0] oc_reg,
                       input logic bias_reg, input int beats);
    int start;
    wait_idle();
    write_reg(REG_IN_CH, ic_reg);
    write_reg(REG_OUT_CH, oc_reg);
    write_reg(REG_BIAS, {6'b0, bias_reg});
    load_stores();
    start = beat_q.size();
    while (beat_q.size() - start < beats) location();
    // hold the sender until everything has drained, then one more location
    wait_idle();
    location();
  endtask

  // Driver: present beats from the queue, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (in_gap > 0) begin
        in_gap        <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (beat_q.size() != 0) begin
        s_axis_tdata  <= {4'b0, beat_q[0].val, beat_q[0].tap, beat_q[0].oc, beat_q[0].ic};
        s_axis_tuser  <= beat_q[0].kind;
        s_axis_tvalid <= 1'b1;
        void'(beat_q.pop_front());
        in_gap        <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: take result beats, compare with the oldest predicted pixel
  always @(posedge clk) begin
    pixel_t exp_px, got_px;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_px = '{m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[5],
                   m_axis_tdata[21:6], m_axis_tlast};
        if (pixel_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", got_px);
        end else begin
          exp_px = pixel_q.pop_front();
          if (got_px !== exp_px) begin
            errors++;
            if (errors <= 10)
              $display("pixel differs: exp oc=%0d r=%0d c=%0d v=%h l=%0d got oc=%0d r=%0d c=%0d v=%h l=%0d",
                       exp_px.oc, exp_px.row, exp_px.col, exp_px.val, exp_px.last,
                       got_px.oc, got_px.row, got_px.col, got_px.val, got_px.last);
          end
        end
      end
      // stall the output at random
      if (out_gap > 0) begin
        out_gap       <= out_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_gap       <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: saturation both ways, bias extremes, dropped beats
    wait_idle();
    write_reg(REG_BIAS, 7'd1);
    send(KIND_WEIGHT, 6'd0, 4'd0, 2'd0, 16'h7fff);
    send(KIND_WEIGHT, 6'd0, 4'd0, 2'd1, 16'h8000);
    send(KIND_WEIGHT, 6'd0, 4'd0, 2'd2, 16'h0000);
    send(KIND_WEIGHT, 6'd0, 4'd0, 2'd3, 16'h0001);
    send(KIND_BIAS, 6'h3f, 4'd0, 2'd3, 16'h8000);
    send(KIND_SAMPLE, 6'd0, 4'hf, 2'd3, 16'h7fff);
    send(KIND_SAMPLE, 6'd0, 4'd0, 2'd0, 16'h8000);
    send(KIND_BIAS, 6'd0, 4'd0, 2'd0, 16'h7fff);
    send(KIND_SAMPLE, 6'd0, 4'd0, 2'd0, 16'hffff);
    send(KIND_SAMPLE, 6'd0, 4'd0, 2'd0, 16'h0000);
    send(KIND_NONE, 6'h3f, 4'hf, 2'd3, 16'hffff);
    send(KIND_SAMPLE, 6'd1, 4'd0, 2'd0, 16'h1234);   // above in_channels, dropped
    send(KIND_SAMPLE, 6'h3f, 4'hf, 2'd3, 16'h8000);  // dropped too
    send(KIND_SAMPLE, 6'd0, 4'd5, 2'd1, 16'h0100);

    // random phases over several settings, clamped values included
    phase(7'd3, 7'd2, 1'b1, 30);
    phase(7'd0, 7'd0, 1'b1, 8);
    phase(7'd1, 7'd31, 1'b0, 4);
    phase(7'($urandom_range(1, 3)), 7'($urandom_range(1, 4)), 1'($urandom()), 16);

    wait_idle();
    if (errors == 0)
      $display("transposed_conv_2x2_stride2: match");
    else
      $display("transposed_conv_2x2_stride2: mismatch");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("transposed_conv_2x2_stride2: mismatch");
    $finish;
  end
endmodule
